[src/projectile_slot_pool_top_macros.svh]
// Assertion helpers for the projectile slot pool.
`ifndef PROJECTILE_SLOT_POOL_TOP_MACROS_SVH
`define PROJECTILE_SLOT_POOL_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Checked under reset disable.
`define PSP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("psp assertion failed");
// Checked during reset as well.
`define PSP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("psp assertion failed");
`else
`define PSP_ASSERT(lbl, clk, rstn, prop)
`define PSP_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[src/psp_pkg.sv]
`timescale 1ns / 1ps
package psp_pkg;

  typedef enum logic [1:0] {
    REQ_LAUNCH    = 2'd0,
    REQ_LAUNCH_AT = 2'd1,
    REQ_TICK      = 2'd2,
    REQ_GET       = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOT_LIVE = 2'd2
  } stat_e;

  localparam logic [1:0] CFG_SPEED    = 2'd0;
  localparam logic [1:0] CFG_LIFETIME = 2'd1;

  localparam logic [15:0] SPEED_RST = 16'd1000;
  localparam logic [23:0] LIFE_RST  = 24'd32768;

  typedef enum logic [3:0] {
    C_IDLE,
    C_DISPATCH,
    C_SEARCH,
    C_NORM_GO,
    C_NORM_WAIT,
    C_STORE,
    C_TICK_PRE,
    C_TICK_RD,
    C_TICK_MUL,
    C_TICK_WB,
    C_GET_RD,
    C_GET_OUT
  } ctrl_state_e;

  typedef enum logic [3:0] {
    N_IDLE,
    N_SQ,
    N_LEN,
    N_DINIT,
    N_DIV,
    N_RINIT,
    N_ROOT,
    N_WR,
    N_DONE
  } norm_state_e;

  // controller -> datapath
  typedef struct packed {
    logic latch;
    logic scan_inc;
    logic norm_go;
    logic store_we;
    logic tick_pre;
    logic rd_tick;
    logic tick_mul;
    logic tick_wb;
    logic rd_get;
    logic resp;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    req_e req;
    logic slot_ok;
    logic scan_end;
    logic scan_alive;
    logic pool_full;
    logic norm_done;
  } dp_stat_t;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [15:0] dir_x;
    logic [15:0] dir_y;
    logic [23:0] age;
    logic [7:0]  kind;
    logic [7:0]  team;
  } entry_t;

endpackage

[src/psp_norm.sv]
`timescale 1ns / 1ps
// Unit-length direction in Q1.14: per component, restoring divide of
// mag^2 << 30 by |a|^2 (one bit per cycle), then a digit-by-digit square
// root (two bits per cycle); n = (isqrt + 1) >> 1.
module psp_norm (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        go_i,
  input  logic [15:0] aim_x_i,
  input  logic [15:0] aim_y_i,
  output logic        done_o,
  output logic [15:0] dir_x_o,
  output logic [15:0] dir_y_o
);

  psp_pkg::norm_state_e st_q, st_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        comp_q, comp_d;

  logic [15:0] magx_q, magy_q;
  logic        negx_q, negy_q;
  logic [30:0] sqx_q, sqy_q;
  logic [31:0] len2_q;
  logic [31:0] rem_q;
  logic [30:0] dbits_q;
  logic [30:0] quo_q;
  logic [31:0] rq_q;
  logic [19:0] rrem_q;
  logic [15:0] root_q;
  logic [15:0] dirx_q, diry_q;

  logic [30:0] msq;
  logic [15:0] mag_cur;
  logic        neg_cur;
  logic [32:0] dtrial;
  logic        dge;
  logic [19:0] rrem_n, rtrial;
  logic        rge;
  logic [15:0] nval, dval;

  assign msq     = comp_q ? sqy_q : sqx_q;
  assign mag_cur = comp_q ? magy_q : magx_q;
  assign neg_cur = comp_q ? negy_q : negx_q;
  assign dtrial  = {rem_q, dbits_q[30]};
  assign dge     = dtrial >= {1'b0, len2_q};
  assign rrem_n  = {rrem_q[17:0], rq_q[31:30]};
  assign rtrial  = {2'b00, root_q, 2'b01};
  assign rge     = rrem_n >= rtrial;
  assign nval    = 16'((17'(root_q) + 17'd1) >> 1);
  assign dval    = (mag_cur == 16'd0) ? 16'd0 : (neg_cur ? 16'(-nval) : nval);

  always_comb begin
    st_d   = st_q;
    cnt_d  = cnt_q;
    comp_d = comp_q;
    case (st_q)
      psp_pkg::N_IDLE: begin
        if (go_i) begin
          st_d   = psp_pkg::N_SQ;
          comp_d = 1'b0;
        end
      end
      psp_pkg::N_SQ:    st_d = psp_pkg::N_LEN;
      psp_pkg::N_LEN:   st_d = psp_pkg::N_DINIT;
      psp_pkg::N_DINIT: begin
        st_d  = psp_pkg::N_DIV;
        cnt_d = 5'd30;
      end
      psp_pkg::N_DIV: begin
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == 5'd0) st_d = psp_pkg::N_RINIT;
      end
      psp_pkg::N_RINIT: begin
        st_d  = psp_pkg::N_ROOT;
        cnt_d = 5'd15;
      end
      psp_pkg::N_ROOT: begin
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == 5'd0) st_d = psp_pkg::N_WR;
      end
      psp_pkg::N_WR: begin
        if (comp_q) begin
          st_d = psp_pkg::N_DONE;
        end else begin
          st_d   = psp_pkg::N_DINIT;
          comp_d = 1'b1;
        end
      end
      psp_pkg::N_DONE:  st_d = psp_pkg::N_IDLE;
      default:          st_d = psp_pkg::N_IDLE;
    endcase
  end

  always_comb begin
    done_o  = (st_q == psp_pkg::N_DONE);
    dir_x_o = dirx_q;
    dir_y_o = diry_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= psp_pkg::N_IDLE;
      cnt_q  <= 5'd0;
      comp_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      comp_q <= comp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      psp_pkg::N_IDLE: begin
        if (go_i) begin
          negx_q <= aim_x_i[15];
          negy_q <= aim_y_i[15];
          magx_q <= aim_x_i[15] ? 16'(-aim_x_i) : aim_x_i;
          magy_q <= aim_y_i[15] ? 16'(-aim_y_i) : aim_y_i;
        end
      end
      psp_pkg::N_SQ: begin
        sqx_q <= 31'(32'(magx_q) * 32'(magx_q));
        sqy_q <= 31'(32'(magy_q) * 32'(magy_q));
      end
      psp_pkg::N_LEN: begin
        len2_q <= 32'(sqx_q) + 32'(sqy_q);
      end
      psp_pkg::N_DINIT: begin
        rem_q   <= 32'(msq[30:1]);
        dbits_q <= {msq[0], 30'd0};
        quo_q   <= 31'd0;
      end
      psp_pkg::N_DIV: begin
        rem_q   <= dge ? 32'(dtrial - {1'b0, len2_q}) : dtrial[31:0];
        quo_q   <= {quo_q[29:0], dge};
        dbits_q <= {dbits_q[29:0], 1'b0};
      end
      psp_pkg::N_RINIT: begin
        rq_q   <= {1'b0, quo_q};
        rrem_q <= 20'd0;
        root_q <= 16'd0;
      end
      psp_pkg::N_ROOT: begin
        rrem_q <= rge ? (rrem_n - rtrial) : rrem_n;
        root_q <= {root_q[14:0], rge};
        rq_q   <= {rq_q[29:0], 2'b00};
      end
      psp_pkg::N_WR: begin
        if (comp_q) diry_q <= dval;
        else        dirx_q <= dval;
      end
      default: ;
    endcase
  end

endmodule

[src/psp_ctrl.sv]
`timescale 1ns / 1ps
module psp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  psp_pkg::dp_stat_t stat_i,
  output psp_pkg::dp_cmd_t  cmd_o,
  output logic              busy_o
);

  psp_pkg::ctrl_state_e st_q, st_d;

  always_comb begin
    st_d = st_q;
    case (st_q)
      psp_pkg::C_IDLE: if (start_i) st_d = psp_pkg::C_DISPATCH;
      psp_pkg::C_DISPATCH: begin
        case (stat_i.req)
          psp_pkg::REQ_LAUNCH:    st_d = psp_pkg::C_SEARCH;
          psp_pkg::REQ_LAUNCH_AT: st_d = stat_i.slot_ok ? psp_pkg::C_NORM_GO
                                                        : psp_pkg::C_IDLE;
          psp_pkg::REQ_TICK:      st_d = psp_pkg::C_TICK_PRE;
          psp_pkg::REQ_GET:       st_d = psp_pkg::C_GET_RD;
          default:                st_d = psp_pkg::C_IDLE;
        endcase
      end
      psp_pkg::C_SEARCH: begin
        if (stat_i.scan_end) begin
          st_d = stat_i.pool_full ? psp_pkg::C_IDLE : psp_pkg::C_NORM_GO;
        end else if (!stat_i.scan_alive) begin
          st_d = psp_pkg::C_NORM_GO;
        end
      end
      psp_pkg::C_NORM_GO:   st_d = psp_pkg::C_NORM_WAIT;
      psp_pkg::C_NORM_WAIT: if (stat_i.norm_done) st_d = psp_pkg::C_STORE;
      psp_pkg::C_STORE:     st_d = psp_pkg::C_IDLE;
      psp_pkg::C_TICK_PRE:  st_d = psp_pkg::C_TICK_RD;
      psp_pkg::C_TICK_RD: begin
        if (stat_i.scan_end)        st_d = psp_pkg::C_IDLE;
        else if (stat_i.scan_alive) st_d = psp_pkg::C_TICK_MUL;
      end
      psp_pkg::C_TICK_MUL:  st_d = psp_pkg::C_TICK_WB;
      psp_pkg::C_TICK_WB:   st_d = psp_pkg::C_TICK_RD;
      psp_pkg::C_GET_RD:    st_d = psp_pkg::C_GET_OUT;
      psp_pkg::C_GET_OUT:   st_d = psp_pkg::C_IDLE;
      default:              st_d = psp_pkg::C_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = (st_q != psp_pkg::C_IDLE);
    case (st_q)
      psp_pkg::C_IDLE:     cmd_o.latch = start_i;
      psp_pkg::C_DISPATCH: begin
        if (stat_i.req == psp_pkg::REQ_LAUNCH_AT && !stat_i.slot_ok) cmd_o.resp = 1'b1;
      end
      psp_pkg::C_SEARCH: begin
        if (stat_i.scan_end) begin
          cmd_o.resp = stat_i.pool_full;
        end else if (stat_i.scan_alive) begin
          cmd_o.scan_inc = 1'b1;
        end
      end
      psp_pkg::C_NORM_GO:  cmd_o.norm_go = 1'b1;
      psp_pkg::C_STORE: begin
        cmd_o.store_we = 1'b1;
        cmd_o.resp     = 1'b1;
      end
      psp_pkg::C_TICK_PRE: cmd_o.tick_pre = 1'b1;
      psp_pkg::C_TICK_RD: begin
        if (stat_i.scan_end)        cmd_o.resp     = 1'b1;
        else if (stat_i.scan_alive) cmd_o.rd_tick  = 1'b1;
        else                        cmd_o.scan_inc = 1'b1;
      end
      psp_pkg::C_TICK_MUL: cmd_o.tick_mul = 1'b1;
      psp_pkg::C_TICK_WB: begin
        cmd_o.tick_wb  = 1'b1;
        cmd_o.scan_inc = 1'b1;
      end
      psp_pkg::C_GET_RD:   cmd_o.rd_get = 1'b1;
      psp_pkg::C_GET_OUT:  cmd_o.resp   = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= psp_pkg::C_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

endmodule

[src/psp_datapath.sv]
`timescale 1ns / 1ps
module psp_datapath #(
  parameter int unsigned SLOTS = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  psp_pkg::dp_cmd_t  cmd_i,
  output psp_pkg::dp_stat_t stat_o,
  input  logic              cfg_valid_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [23:0]       cfg_data_i,
  input  logic [1:0]        req_type_i,
  input  logic [7:0]        kind_i,
  input  logic signed [7:0]  team_i,
  input  logic signed [31:0] start_x_i,
  input  logic signed [31:0] start_y_i,
  input  logic signed [15:0] aim_x_i,
  input  logic signed [15:0] aim_y_i,
  input  logic [6:0]        slot_i,
  input  logic [15:0]       delta_time_i,
  output logic              result_valid_o,
  output logic [1:0]        status_o,
  output logic [6:0]        used_slot_o,
  output logic              live_o,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic [7:0]        out_kind_o,
  output logic signed [7:0]  out_team_o,
  output logic [7:0]        high_water_o
);

  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);

  // latched request
  psp_pkg::req_e req_q;
  logic [7:0]  kind_q, team_q;
  logic [31:0] sx_q, sy_q;
  logic [15:0] ax_q, ay_q;
  logic [6:0]  slot_q;
  logic [15:0] dt_q;

  logic [15:0] speed_q;
  logic [23:0] life_q;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] scan_q;
  logic [SLOTS-1:0] alive_q;

  psp_pkg::entry_t mem [SLOTS];
  psp_pkg::entry_t rdata_q, wdata;
  logic            we, re;
  logic [SW-1:0]   waddr, raddr;

  logic [31:0]        sd_q;
  logic signed [48:0] px_q, py_q;

  logic [SW-1:0] slot_idx, scan_idx;
  logic slot_ok, get_ok, scan_end, pool_full;
  logic norm_done;
  logic [15:0] ndir_x, ndir_y;

  logic signed [48:0] sum_x, sum_y;
  logic [31:0] new_x, new_y;
  logic [24:0] age_sum;
  logic [23:0] age_new;
  logic        die;

  psp_pkg::stat_e res_status;
  logic [6:0]  res_used;
  logic        res_live;
  logic [31:0] res_x, res_y;
  logic [7:0]  res_kind, res_team;

  logic        valid_q;
  psp_pkg::stat_e status_q;
  logic [6:0]  used_q;
  logic        live_q;
  logic [31:0] x_q, y_q;
  logic [7:0]  okind_q, oteam_q, hw_q;

  assign slot_idx  = SW'(slot_q);
  assign scan_idx  = scan_q[SW-1:0];
  assign slot_ok   = 32'(slot_q) < SLOTS;
  assign get_ok    = slot_ok && (32'(slot_q) < 32'(count_q)) && alive_q[slot_idx];
  assign scan_end  = scan_q >= count_q;
  assign pool_full = 32'(scan_q) == SLOTS;

  always_comb begin
    stat_o.req        = req_q;
    stat_o.slot_ok    = slot_ok;
    stat_o.scan_end   = scan_end;
    stat_o.scan_alive = scan_end ? 1'b0 : alive_q[scan_idx];
    stat_o.pool_full  = pool_full;
    stat_o.norm_done  = norm_done;
  end

  psp_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .go_i    (cmd_i.norm_go),
    .aim_x_i (ax_q),
    .aim_y_i (ay_q),
    .done_o  (norm_done),
    .dir_x_o (ndir_x),
    .dir_y_o (ndir_y)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q  <= psp_pkg::req_e'(req_type_i);
      kind_q <= kind_i;
      team_q <= team_i;
      sx_q   <= start_x_i;
      sy_q   <= start_y_i;
      ax_q   <= aim_x_i;
      ay_q   <= aim_y_i;
      slot_q <= slot_i;
      dt_q   <= delta_time_i;
    end
    if (cmd_i.tick_pre) sd_q <= 32'(speed_q) * 32'(dt_q);
    if (cmd_i.tick_mul) begin
      px_q <= $signed(rdata_q.dir_x) * $signed({1'b0, sd_q});
      py_q <= $signed(rdata_q.dir_y) * $signed({1'b0, sd_q});
    end
  end

  // tick update: round Q.30 step to Q.8, ties up
  assign sum_x   = px_q + 49'sd2097152;
  assign sum_y   = py_q + 49'sd2097152;
  assign new_x   = rdata_q.pos_x + {{5{sum_x[48]}}, sum_x[48:22]};
  assign new_y   = rdata_q.pos_y + {{5{sum_y[48]}}, sum_y[48:22]};
  assign age_sum = {1'b0, rdata_q.age} + {9'd0, dt_q};
  assign age_new = age_sum[24] ? 24'hFFFFFF : age_sum[23:0];
  assign die     = age_new >= life_q;

  always_comb begin
    we    = cmd_i.store_we | cmd_i.tick_wb;
    re    = cmd_i.rd_tick | cmd_i.rd_get;
    raddr = cmd_i.rd_get ? slot_idx : scan_idx;
    waddr = scan_idx;
    wdata = rdata_q;
    if (cmd_i.store_we) begin
      waddr = (req_q == psp_pkg::REQ_LAUNCH) ? scan_idx : slot_idx;
      wdata.pos_x = sx_q;
      wdata.pos_y = sy_q;
      wdata.dir_x = ndir_x;
      wdata.dir_y = ndir_y;
      wdata.age   = 24'd0;
      wdata.kind  = kind_q;
      wdata.team  = team_q;
    end else begin
      wdata.pos_x = new_x;
      wdata.pos_y = new_y;
      wdata.age   = age_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[raddr];
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.store_we && req_q == psp_pkg::REQ_LAUNCH && scan_q == count_q) begin
      count_d = count_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q <= psp_pkg::SPEED_RST;
      life_q  <= psp_pkg::LIFE_RST;
      count_q <= '0;
      scan_q  <= '0;
      alive_q <= '0;
      valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          psp_pkg::CFG_SPEED:    speed_q <= cfg_data_i[15:0];
          psp_pkg::CFG_LIFETIME: life_q  <= cfg_data_i;
          default: ;
        endcase
      end
      count_q <= count_d;
      if (cmd_i.latch)         scan_q <= '0;
      else if (cmd_i.scan_inc) scan_q <= scan_q + CW'(1);
      if (cmd_i.store_we)          alive_q[waddr] <= 1'b1;
      else if (cmd_i.tick_wb && die) alive_q[scan_idx] <= 1'b0;
      valid_q <= cmd_i.resp;
    end
  end

  always_comb begin
    res_status = psp_pkg::ST_OK;
    res_used   = 7'd0;
    res_live   = 1'b0;
    res_x      = 32'd0;
    res_y      = 32'd0;
    res_kind   = 8'd0;
    res_team   = 8'd0;
    case (req_q)
      psp_pkg::REQ_LAUNCH: begin
        if (pool_full) res_status = psp_pkg::ST_FULL;
        else           res_used   = 7'(scan_q);
      end
      psp_pkg::REQ_LAUNCH_AT: begin
        res_used = slot_q;
        if (!slot_ok) res_status = psp_pkg::ST_NOT_LIVE;
      end
      psp_pkg::REQ_GET: begin
        res_used = slot_q;
        if (get_ok) begin
          res_live = 1'b1;
          res_x    = rdata_q.pos_x;
          res_y    = rdata_q.pos_y;
          res_kind = rdata_q.kind;
          res_team = rdata_q.team;
        end else begin
          res_status = psp_pkg::ST_NOT_LIVE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.resp) begin
      status_q <= res_status;
      used_q   <= res_used;
      live_q   <= res_live;
      x_q      <= res_x;
      y_q      <= res_y;
      okind_q  <= res_kind;
      oteam_q  <= res_team;
      hw_q     <= 8'(count_d);
    end
  end

  assign result_valid_o = valid_q;
  assign status_o       = status_q;
  assign used_slot_o    = used_q;
  assign live_o         = live_q;
  assign out_x_o        = x_q;
  assign out_y_o        = y_q;
  assign out_kind_o     = okind_q;
  assign out_team_o     = oteam_q;
  assign high_water_o   = hw_q;

endmodule

[src/projectile_slot_pool_top.sv]
`timescale 1ns / 1ps
// Projectile slot pool: SLOTS moving entries, four request kinds
// (launch, launch at slot, tick, get).
// Request channel: drive the fields with start_i high while busy_o is low;
// the request is taken at that edge and busy_o rises the next cycle.
// Result channel: one beat per request, shown for one cycle with
// result_valid_o high; busy_o is already low in that cycle, so the next
// request may be taken at the same edge. The receiver cannot stall.
// Config channel: cfg_ready_o is always high; write only while idle.
// Request flow, request to result strobe:
//   get reads the entry; launch at slot runs the normalizer unless the
//   slot is out of range; launch walks the live slots before the first
//   free one (at most high_water), reporting full when none is free
//   (free-slot walk, one flag per cycle, then the serial normalizer:
//   two 31-step divides and two 16-step roots); tick walks the slots
//   below count, each live slot in turn read, multiplied, written back.
// Reset clears the count, the live flags and the registers to speed 1000,
// lifetime 0.5 s; entry memory needs no clearing since the data of a
// slot that is not live is never used.
`include "projectile_slot_pool_top_macros.svh"
module projectile_slot_pool_top #(
  parameter int unsigned SLOTS = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         req_type_i,
  input  logic [7:0]         kind_i,
  input  logic signed [7:0]  team_i,
  input  logic signed [31:0] start_x_i,
  input  logic signed [31:0] start_y_i,
  input  logic signed [15:0] aim_x_i,
  input  logic signed [15:0] aim_y_i,
  input  logic [6:0]         slot_i,
  input  logic [15:0]        delta_time_i,
  output logic               result_valid_o,
  output logic [1:0]         status_o,
  output logic [6:0]         used_slot_o,
  output logic               live_o,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic [7:0]         out_kind_o,
  output logic signed [7:0]  out_team_o,
  output logic [7:0]         high_water_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [23:0]        cfg_data_i
);

  psp_pkg::dp_cmd_t  cmd;
  psp_pkg::dp_stat_t stat;

  // config writes are always accepted and registered
  assign cfg_ready_o = 1'b1;

  psp_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  psp_datapath #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .req_type_i     (req_type_i),
    .kind_i         (kind_i),
    .team_i         (team_i),
    .start_x_i      (start_x_i),
    .start_y_i      (start_y_i),
    .aim_x_i        (aim_x_i),
    .aim_y_i        (aim_y_i),
    .slot_i         (slot_i),
    .delta_time_i   (delta_time_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .used_slot_o    (used_slot_o),
    .live_o         (live_o),
    .out_x_o        (out_x_o),
    .out_y_o        (out_y_o),
    .out_kind_o     (out_kind_o),
    .out_team_o     (out_team_o),
    .high_water_o   (high_water_o)
  );

  // one result beat per request, never two in a row
  `PSP_ASSERT(a_single_beat, clk_i, rst_ni, result_valid_o |=> !result_valid_o)
  // result beat comes out as the controller returns to idle
  `PSP_ASSERT(a_beat_idle, clk_i, rst_ni, result_valid_o |-> !busy_o)
  // a taken request keeps the block busy until its result
  `PSP_ASSERT(a_accept_busy, clk_i, rst_ni, (start_i && !busy_o) |=> busy_o)
  // pool full only reported with the count at capacity
  `PSP_ASSERT(a_full_count, clk_i, rst_ni,
    (result_valid_o && status_o == psp_pkg::ST_FULL) |-> (high_water_o == 8'(SLOTS)))

endmodule
